// ----- rtl/fbr_pkg.sv -----
package fbr_pkg;

  localparam int MAX_PAYLOAD_DEF = 32;
  localparam int FRAME_SLOTS_DEF = 4;

  // Frame lengths travel in 7 bits, enough for the default slot size of 32.
  localparam int LEN_W = 7;

  typedef enum logic [1:0] {
    PS_HUNT,
    PS_SIZE,
    PS_DATA,
    PS_SUM
  } parse_state_t;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_DISPATCH,
    CS_ISSUE,
    CS_LOAD
  } ctl_state_t;

  typedef enum logic [1:0] {
    RK_STATUS = 2'd0,
    RK_DATA   = 2'd1,
    RK_EMPTY  = 2'd2
  } res_kind_t;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_ACCEPT    = 3'd1,
    EV_BAD_SUM   = 3'd2,
    EV_TOO_LONG  = 3'd3,
    EV_RING_FULL = 3'd4
  } event_t;

  typedef struct packed {
    logic capture;
    logic line;
    logic empty;
    logic zero_frame;
    logic start_read;
    logic issue_read;
    logic load_byte;
    logic pop;
  } fbr_cmd_t;

  typedef struct packed {
    logic kind;
    logic ring_empty;
    logic len_zero;
    logic out_free;
    logic last_byte;
  } fbr_status_t;

endpackage

// ----- rtl/fbr_if.sv -----
interface fbr_req_if
  import fbr_pkg::*;
();
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] rx_byte;

  modport source (output valid, output kind, output rx_byte, input ready);
  modport sink (input valid, input kind, input rx_byte, output ready);
endinterface

interface fbr_res_if
  import fbr_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [1:0]       result_kind;
  logic [2:0]       event_res;
  logic [7:0]       data_byte;
  logic [LEN_W-1:0] frame_length;
  logic             last;

  modport source (output valid, output result_kind, output event_res, output data_byte,
                  output frame_length, output last, input ready);
  modport sink (input valid, input result_kind, input event_res, input data_byte,
                input frame_length, input last, output ready);
endinterface

// ----- rtl/fbr_ctrl.sv -----
module fbr_ctrl
  import fbr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  fbr_status_t st,
  output fbr_cmd_t    cmd
);

  ctl_state_t state;
  ctl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      CS_IDLE: begin
        if (in_valid) begin
          state_next = CS_DISPATCH;
        end
      end
      CS_DISPATCH: begin
        if (st.out_free) begin
          if (st.kind && !st.ring_empty && !st.len_zero) begin
            state_next = CS_ISSUE;
          end else begin
            state_next = CS_IDLE;
          end
        end
      end
      CS_ISSUE: begin
        state_next = CS_LOAD;
      end
      CS_LOAD: begin
        if (st.out_free) begin
          state_next = st.last_byte ? CS_IDLE : CS_ISSUE;
        end
      end
      default: begin
        state_next = CS_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      CS_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      CS_DISPATCH: begin
        if (st.out_free) begin
          if (!st.kind) begin
            cmd.line = 1'b1;
          end else if (st.ring_empty) begin
            cmd.empty = 1'b1;
          end else if (st.len_zero) begin
            cmd.zero_frame = 1'b1;
            cmd.pop        = 1'b1;
          end else begin
            cmd.start_read = 1'b1;
          end
        end
      end
      CS_ISSUE: begin
        cmd.issue_read = 1'b1;
      end
      CS_LOAD: begin
        if (st.out_free) begin
          cmd.load_byte = 1'b1;
          cmd.pop       = st.last_byte;
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ----- rtl/fbr_dp.sv -----
module fbr_dp
  import fbr_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
  parameter int FRAME_SLOTS = FRAME_SLOTS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  fbr_cmd_t         cmd,
  output fbr_status_t      st,
  input  logic             cfg_we,
  input  logic [7:0]       cfg_wdata,
  input  logic             in_kind,
  input  logic [7:0]       in_byte,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       out_result_kind,
  output logic [2:0]       out_event_res,
  output logic [7:0]       out_data_byte,
  output logic [LEN_W-1:0] out_frame_length,
  output logic             out_last
);

  localparam int DEPTH  = FRAME_SLOTS * MAX_PAYLOAD;
  localparam int SLOT_W = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
  localparam int CNT_W  = $clog2(FRAME_SLOTS + 1);
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [ADDR_W-1:0] SLOT_SPAN = ADDR_W'(MAX_PAYLOAD);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(FRAME_SLOTS - 1);

  logic             kind_q;
  logic [7:0]       byte_q;
  logic [7:0]       start_byte;

  parse_state_t     parse_state;
  parse_state_t     parse_state_next;
  logic [LEN_W-1:0] declared_length;
  logic [LEN_W-1:0] declared_length_next;
  logic [LEN_W-1:0] byte_position;
  logic [LEN_W-1:0] byte_position_next;
  logic [7:0]       running_sum;
  logic [7:0]       running_sum_next;
  logic             drop_pending;
  logic             drop_pending_next;
  event_t           line_event;
  logic             commit;
  logic             store_we;

  logic [SLOT_W-1:0] write_slot;
  logic [SLOT_W-1:0] read_slot;
  logic [CNT_W-1:0]  slots_filled;
  logic [LEN_W-1:0]  slot_lengths [FRAME_SLOTS];
  logic              ring_full;

  logic [7:0]        frame_store [DEPTH];
  logic [7:0]        store_q;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [LEN_W-1:0]  rd_pos;
  logic [LEN_W-1:0]  rd_len;

  assign ring_full = (slots_filled == CNT_W'(FRAME_SLOTS));

  assign st.kind       = kind_q;
  assign st.ring_empty = (slots_filled == '0);
  assign st.len_zero   = (slot_lengths[read_slot] == '0);
  assign st.out_free   = !out_valid || out_ready;
  assign st.last_byte  = ((rd_pos + LEN_W'(1)) == rd_len);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_q <= in_kind;
      byte_q <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte <= '0;
    end else if (cfg_we) begin
      start_byte <= cfg_wdata;
    end
  end

  // One line byte through the frame parser.
  always_comb begin
    parse_state_next     = parse_state;
    declared_length_next = declared_length;
    byte_position_next   = byte_position;
    running_sum_next     = running_sum;
    drop_pending_next    = drop_pending;
    line_event           = EV_NONE;
    commit               = 1'b0;
    store_we             = 1'b0;
    case (parse_state)
      PS_HUNT: begin
        if (byte_q == start_byte) begin
          parse_state_next = PS_SIZE;
        end
      end
      PS_SIZE: begin
        if (byte_q > 8'(MAX_PAYLOAD)) begin
          parse_state_next = PS_HUNT;
          line_event       = EV_TOO_LONG;
        end else begin
          declared_length_next = byte_q[LEN_W-1:0];
          byte_position_next   = '0;
          running_sum_next     = '0;
          drop_pending_next    = ring_full;
          parse_state_next     = (byte_q == '0) ? PS_SUM : PS_DATA;
        end
      end
      PS_DATA: begin
        store_we           = !drop_pending;
        running_sum_next   = running_sum + byte_q;
        byte_position_next = byte_position + LEN_W'(1);
        if (byte_position_next >= declared_length) begin
          parse_state_next = PS_SUM;
        end
      end
      PS_SUM: begin
        if (running_sum != byte_q) begin
          line_event = EV_BAD_SUM;
        end else if (drop_pending || ring_full) begin
          line_event = EV_RING_FULL;
        end else begin
          line_event = EV_ACCEPT;
          commit     = 1'b1;
        end
        drop_pending_next = 1'b0;
        parse_state_next  = PS_HUNT;
      end
      default: begin
        parse_state_next = PS_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_state     <= PS_HUNT;
      declared_length <= '0;
      byte_position   <= '0;
      running_sum     <= '0;
      drop_pending    <= 1'b0;
    end else if (cmd.line) begin
      parse_state     <= parse_state_next;
      declared_length <= declared_length_next;
      byte_position   <= byte_position_next;
      running_sum     <= running_sum_next;
      drop_pending    <= drop_pending_next;
    end
  end

  // Ring pointers. A frame is committed and a frame is popped in different cycles.
  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot   <= '0;
      read_slot    <= '0;
      slots_filled <= '0;
    end else if (cmd.line && commit) begin
      write_slot   <= (write_slot == LAST_SLOT) ? '0 : write_slot + SLOT_W'(1);
      slots_filled <= slots_filled + CNT_W'(1);
    end else if (cmd.pop) begin
      read_slot    <= (read_slot == LAST_SLOT) ? '0 : read_slot + SLOT_W'(1);
      slots_filled <= slots_filled - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.line && commit) begin
      slot_lengths[write_slot] <= declared_length;
    end
  end

  assign wr_addr = ADDR_W'(write_slot) * SLOT_SPAN + ADDR_W'(byte_position);
  assign rd_addr = ADDR_W'(read_slot) * SLOT_SPAN + ADDR_W'(rd_pos);

  always_ff @(posedge clk) begin
    if (cmd.line && store_we) begin
      frame_store[wr_addr] <= byte_q;
    end
    if (cmd.issue_read) begin
      store_q <= frame_store[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_read) begin
      rd_pos <= '0;
      rd_len <= slot_lengths[read_slot];
    end else if (cmd.load_byte) begin
      rd_pos <= rd_pos + LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.line || cmd.empty || cmd.zero_frame || cmd.load_byte) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.line) begin
      out_result_kind  <= RK_STATUS;
      out_event_res    <= line_event;
      out_data_byte    <= '0;
      out_frame_length <= '0;
      out_last         <= 1'b1;
    end else if (cmd.empty) begin
      out_result_kind  <= RK_EMPTY;
      out_event_res    <= EV_NONE;
      out_data_byte    <= '0;
      out_frame_length <= '0;
      out_last         <= 1'b1;
    end else if (cmd.zero_frame) begin
      out_result_kind  <= RK_DATA;
      out_event_res    <= EV_NONE;
      out_data_byte    <= '0;
      out_frame_length <= '0;
      out_last         <= 1'b1;
    end else if (cmd.load_byte) begin
      out_result_kind  <= RK_DATA;
      out_event_res    <= EV_NONE;
      out_data_byte    <= store_q;
      out_frame_length <= rd_len;
      out_last         <= st.last_byte;
    end
  end

endmodule

// ----- rtl/framed_byte_receiver_with_frame_ring.sv -----
// Receives line bytes framed as start byte, length, payload and an 8-bit additive
// checksum, and keeps each good frame in a ring of FRAME_SLOTS slots of MAX_PAYLOAD
// bytes. Every word on req is either a line byte (kind 0), which yields one status
// word on res, or a take request (kind 1), which yields the oldest frame's payload
// bytes with last set on the final one, a single data word for an empty frame, or a
// single ring-empty word. One request is handled at a time: a new word is accepted
// only once the controller is back in idle, and a request may be accepted while its
// predecessor's result still waits on res. A take of a frame steps through dispatch,
// then an issue and a load state for each byte, as the frame memory's read data is
// registered before it reaches the output register. Back-pressure on res stalls the
// dispatch and load steps. The start byte register may only be written while
// no request is in progress.
module framed_byte_receiver_with_frame_ring
  import fbr_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
  parameter int FRAME_SLOTS = FRAME_SLOTS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  fbr_req_if.sink    req,
  fbr_res_if.source  res,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);

  fbr_cmd_t    cmd;
  fbr_status_t st;

  fbr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .st       (st),
    .cmd      (cmd)
  );

  fbr_dp #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .FRAME_SLOTS (FRAME_SLOTS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .st               (st),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_kind          (req.kind),
    .in_byte          (req.rx_byte),
    .out_valid        (res.valid),
    .out_ready        (res.ready),
    .out_result_kind  (res.result_kind),
    .out_event_res    (res.event_res),
    .out_data_byte    (res.data_byte),
    .out_frame_length (res.frame_length),
    .out_last         (res.last)
  );

  // A request is worked on alone, so the input is closed in the cycle after one is accepted.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("input accepted in back-to-back cycles");

  // A frame is only handed out and released while the ring holds one.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> !st.ring_empty)
    else $error("frame popped from an empty ring");

  // The output register is loaded only when its word is gone or leaving.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.line || cmd.empty || cmd.zero_frame || cmd.load_byte |-> !res.valid || res.ready)
    else $error("pending result overwritten");

endmodule
